[src/bsl_pkg.sv]
package bsl_pkg;

    localparam int CAPACITY_DEF = 16;

    localparam int ACTION_W = 2;
    localparam int VALUE_W  = 32;
    localparam int POS_W    = 5;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_APPEND = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_DELETE = 2'd2;
    localparam logic [ACTION_W-1:0] ACT_READ   = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BADPOS = 2'd3;

    typedef enum logic [2:0] {
        OP_HOLD,
        OP_INSERT,
        OP_APPEND,
        OP_DELETE,
        OP_ROTATE
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
    } t_cell_ctl;

endpackage

[src/bsl_cell.sv]
module bsl_cell #(
    parameter int INDEX = 0,
    parameter int IW    = 4
) (
    input  logic                            i_clk,
    input  bsl_pkg::t_cell_ctl              i_ctl,
    input  logic [IW-1:0]                   i_ref,
    input  logic [bsl_pkg::VALUE_W-1:0]     i_value,
    input  logic [bsl_pkg::VALUE_W-1:0]     i_left,
    input  logic [bsl_pkg::VALUE_W-1:0]     i_right,
    input  logic [bsl_pkg::VALUE_W-1:0]     i_wrap,
    output logic [bsl_pkg::VALUE_W-1:0]     o_entry
);

    localparam logic [IW-1:0] MY_IDX = IW'(INDEX);

    logic [bsl_pkg::VALUE_W-1:0] r_entry;
    logic [bsl_pkg::VALUE_W-1:0] n_entry;

    always_comb begin
        n_entry = r_entry;
        unique case (i_ctl.op)
            bsl_pkg::OP_INSERT: begin
                n_entry = (INDEX == 0) ? i_value : i_left;
            end
            bsl_pkg::OP_APPEND: begin
                if (MY_IDX == i_ref) n_entry = i_value;
            end
            bsl_pkg::OP_DELETE: begin
                if (MY_IDX >= i_ref) n_entry = i_right;
            end
            bsl_pkg::OP_ROTATE: begin
                if (MY_IDX == i_ref) n_entry = i_wrap;
                else if (MY_IDX < i_ref) n_entry = i_right;
            end
            default: n_entry = r_entry;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;

endmodule

[src/bounded_shift_list_top.sv]
// A single-word result (insert, append, delete, status) is valid the cycle after accept.
// Readout: accept enters S_READ, then words come from cell 0, one per cycle unless stalled.
// One operation per cycle unless output stalls; a readout holds off input until its last word.
// Every operation is one parallel step over the cell row; readout rotates the row once per word.
// Reset (synchronous, active low) empties the list, drops output valid; entries are not cleared.
module bounded_shift_list_top #(
    parameter int CAPACITY = bsl_pkg::CAPACITY_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [bsl_pkg::ACTION_W-1:0]  i_action,
    input  logic signed [bsl_pkg::VALUE_W-1:0] i_value,
    input  logic [bsl_pkg::POS_W-1:0]     i_position,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [bsl_pkg::STATUS_W-1:0]  o_status,
    output logic signed [bsl_pkg::VALUE_W-1:0] o_data,
    output logic                          o_last,
    output logic [bsl_pkg::COUNT_W-1:0]   o_count
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int PW = (CW > bsl_pkg::POS_W) ? CW : bsl_pkg::POS_W;
    localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

    typedef enum logic {
        S_IDLE,
        S_READ
    } t_state;

    t_state                         r_state;
    logic [CW-1:0]                  r_count;
    logic [IW-1:0]                  r_idx;
    logic                           r_out_valid;
    logic [bsl_pkg::STATUS_W-1:0]   r_status;
    logic [bsl_pkg::VALUE_W-1:0]    r_data;
    logic                           r_last;

    logic                           in_acc;
    logic                           out_free;
    logic                           full;
    logic                           empty;
    logic                           pos_ok;
    logic [PW-1:0]                  pos_ext;
    logic [PW-1:0]                  cnt_ext;
    logic [IW-1:0]                  cnt_last;
    logic                           rd_last;
    bsl_pkg::t_cell_ctl             cell_ctl;
    logic [IW-1:0]                  cell_ref;
    logic [bsl_pkg::VALUE_W-1:0]    w_entry [CAPACITY];

    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state == S_READ) || (r_out_valid && i_out_stall);
    assign in_acc     = i_in_valid && !o_in_stall;

    assign full     = (r_count == CAP_CNT);
    assign empty    = (r_count == '0);
    assign pos_ext  = PW'(i_position);
    assign cnt_ext  = PW'(r_count);
    assign pos_ok   = (pos_ext != '0) && (pos_ext <= cnt_ext);
    assign cnt_last = IW'(r_count - CW'(1));
    assign rd_last  = (r_idx == cnt_last);

    always_comb begin
        cell_ctl.op = bsl_pkg::OP_HOLD;
        cell_ref    = '0;
        if (r_state == S_READ) begin
            if (out_free) begin
                cell_ctl.op = bsl_pkg::OP_ROTATE;
                cell_ref    = cnt_last;
            end
        end else if (in_acc) begin
            unique case (i_action)
                bsl_pkg::ACT_INSERT: begin
                    if (!full) cell_ctl.op = bsl_pkg::OP_INSERT;
                end
                bsl_pkg::ACT_APPEND: begin
                    if (!full) cell_ctl.op = bsl_pkg::OP_APPEND;
                    cell_ref = IW'(r_count);
                end
                bsl_pkg::ACT_DELETE: begin
                    if (!empty && pos_ok) cell_ctl.op = bsl_pkg::OP_DELETE;
                    cell_ref = IW'(pos_ext - PW'(1));
                end
                default: cell_ctl.op = bsl_pkg::OP_HOLD;
            endcase
        end
    end

    for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
        bsl_cell #(
            .INDEX (k),
            .IW    (IW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_ctl   (cell_ctl),
            .i_ref   (cell_ref),
            .i_value (i_value),
            .i_left  ((k == 0) ? i_value : w_entry[(k == 0) ? 0 : k - 1]),
            .i_right ((k == CAPACITY - 1) ? w_entry[k] : w_entry[(k == CAPACITY - 1) ? k : k + 1]),
            .i_wrap  (w_entry[0]),
            .o_entry (w_entry[k])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_data <= '0;
                        r_last <= 1'b1;
                        unique case (i_action)
                            bsl_pkg::ACT_INSERT, bsl_pkg::ACT_APPEND: begin
                                r_out_valid <= 1'b1;
                                if (full) begin
                                    r_status <= bsl_pkg::ST_FULL;
                                end else begin
                                    r_status <= bsl_pkg::ST_OK;
                                    r_count  <= r_count + CW'(1);
                                end
                            end
                            bsl_pkg::ACT_DELETE: begin
                                r_out_valid <= 1'b1;
                                if (empty) begin
                                    r_status <= bsl_pkg::ST_EMPTY;
                                end else if (!pos_ok) begin
                                    r_status <= bsl_pkg::ST_BADPOS;
                                end else begin
                                    r_status <= bsl_pkg::ST_OK;
                                    r_count  <= r_count - CW'(1);
                                end
                            end
                            default: begin
                                if (empty) begin
                                    r_out_valid <= 1'b1;
                                    r_status    <= bsl_pkg::ST_EMPTY;
                                end else begin
                                    r_out_valid <= 1'b0;
                                    r_idx       <= '0;
                                    r_state     <= S_READ;
                                end
                            end
                        endcase
                    end else if (r_out_valid && !i_out_stall) begin
                        r_out_valid <= 1'b0;
                    end
                end
                S_READ: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_status    <= bsl_pkg::ST_OK;
                        r_data      <= w_entry[0];
                        r_last      <= rd_last;
                        r_idx       <= r_idx + IW'(1);
                        if (rd_last) r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_data      = r_data;
    assign o_last      = r_last;
    assign o_count     = bsl_pkg::COUNT_W'(r_count);

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CAP_CNT)
        else $error("fill count above capacity");

    a_count_steady: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !in_acc |=> $stable(r_count))
        else $error("fill count moved without an accepted word");

    a_mid_word_in_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_last) |-> (r_state == S_READ))
        else $error("non-final word outside readout");

    a_read_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |-> (CW'(r_idx) < r_count))
        else $error("readout index past fill count");

    a_read_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_READ) |-> !in_acc)
        else $error("word accepted during readout");

endmodule
